// ===== sv/scle_pkg.sv =====
// shared types, constants and key tables for the scan code line editor
// used by every module of the block but the ram; depends on nothing

package scle_pkg;

  localparam int LINE_DEPTH = 128;
  localparam int CNT_W      = $clog2(LINE_DEPTH);
  localparam int CHAR_W     = 7;

  localparam logic [7:0] SC_CTRL_MAKE  = 8'h1D;
  localparam logic [7:0] SC_CTRL_BREAK = 8'h9D;
  localparam logic [7:0] SC_ALT_MAKE   = 8'h38;
  localparam logic [7:0] SC_ALT_BREAK  = 8'hB8;
  localparam logic [7:0] SC_SHIFT_MAKE = 8'h2A;
  localparam logic [7:0] SC_SHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_CAPS_BREAK = 8'hBA;
  localparam logic [7:0] SC_ENTER      = 8'h1C;
  localparam logic [7:0] SC_L          = 8'h26;
  localparam logic [7:0] SC_F1         = 8'h3B;
  localparam logic [7:0] SC_F3         = 8'h3D;
  localparam logic [7:0] SC_TAB        = 8'h0F;
  localparam logic [7:0] SC_BKSP       = 8'h0E;

  localparam logic [CHAR_W-1:0] ASCII_BS    = 7'h08;
  localparam logic [CHAR_W-1:0] ASCII_TAB   = 7'h09;
  localparam logic [CHAR_W-1:0] ASCII_LF    = 7'h0A;
  localparam logic [CHAR_W-1:0] ASCII_SPACE = 7'h20;
  localparam logic [CHAR_W-1:0] ASCII_LC_A  = 7'h61;
  localparam logic [CHAR_W-1:0] ASCII_LC_Z  = 7'h7A;

  localparam logic [2:0] ECHO_NONE = 3'd0;
  localparam logic [2:0] ECHO_ONCE = 3'd1;
  localparam logic [2:0] ECHO_TAB  = 3'd4;

  typedef enum logic [2:0] {
    KEY_NONE,
    KEY_CLEAR,
    KEY_SWITCH,
    KEY_TAB,
    KEY_BKSP,
    KEY_CHAR
  } key_kind_t;

  typedef struct packed {
    key_kind_t         kind;
    logic [CHAR_W-1:0] ch;
    logic [1:0]        target;
  } key_info_t;

  typedef struct packed {
    logic [CHAR_W-1:0] echo_char;
    logic [2:0]        echo_count;
    logic              clear_req;
    logic              switch_valid;
    logic [1:0]        switch_target;
    logic              deleted_tab;
    logic [6:0]        line_length;
    logic              line_wrapped;
  } result_t;

  function automatic logic [CHAR_W-1:0] plain_char(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      6'h02: c = 7'h31;
      6'h03: c = 7'h32;
      6'h04: c = 7'h33;
      6'h05: c = 7'h34;
      6'h06: c = 7'h35;
      6'h07: c = 7'h36;
      6'h08: c = 7'h37;
      6'h09: c = 7'h38;
      6'h0A: c = 7'h39;
      6'h0B: c = 7'h30;
      6'h0C: c = 7'h2D;
      6'h0D: c = 7'h3D;
      6'h0E: c = 7'h08;
      6'h0F: c = 7'h09;
      6'h10: c = 7'h71;
      6'h11: c = 7'h77;
      6'h12: c = 7'h65;
      6'h13: c = 7'h72;
      6'h14: c = 7'h74;
      6'h15: c = 7'h79;
      6'h16: c = 7'h75;
      6'h17: c = 7'h69;
      6'h18: c = 7'h6F;
      6'h19: c = 7'h70;
      6'h1A: c = 7'h5B;
      6'h1B: c = 7'h5D;
      6'h1C: c = 7'h0A;
      6'h1E: c = 7'h61;
      6'h1F: c = 7'h73;
      6'h20: c = 7'h64;
      6'h21: c = 7'h66;
      6'h22: c = 7'h67;
      6'h23: c = 7'h68;
      6'h24: c = 7'h6A;
      6'h25: c = 7'h6B;
      6'h26: c = 7'h6C;
      6'h27: c = 7'h3B;
      6'h28: c = 7'h27;
      6'h29: c = 7'h60;
      6'h2B: c = 7'h5C;
      6'h2C: c = 7'h7A;
      6'h2D: c = 7'h78;
      6'h2E: c = 7'h63;
      6'h2F: c = 7'h76;
      6'h30: c = 7'h62;
      6'h31: c = 7'h6E;
      6'h32: c = 7'h6D;
      6'h33: c = 7'h2C;
      6'h34: c = 7'h2E;
      6'h35: c = 7'h2F;
      6'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] shift_char(input logic [5:0] idx);
    logic [CHAR_W-1:0] c;
    case (idx)
      6'h02: c = 7'h21;
      6'h03: c = 7'h40;
      6'h04: c = 7'h23;
      6'h05: c = 7'h24;
      6'h06: c = 7'h25;
      6'h07: c = 7'h5E;
      6'h08: c = 7'h26;
      6'h09: c = 7'h2A;
      6'h0A: c = 7'h28;
      6'h0B: c = 7'h29;
      6'h0C: c = 7'h5F;
      6'h0D: c = 7'h2B;
      6'h0E: c = 7'h08;
      6'h0F: c = 7'h09;
      6'h10: c = 7'h51;
      6'h11: c = 7'h57;
      6'h12: c = 7'h45;
      6'h13: c = 7'h52;
      6'h14: c = 7'h54;
      6'h15: c = 7'h59;
      6'h16: c = 7'h55;
      6'h17: c = 7'h49;
      6'h18: c = 7'h4F;
      6'h19: c = 7'h50;
      6'h1A: c = 7'h7B;
      6'h1B: c = 7'h7D;
      6'h1C: c = 7'h0A;
      6'h1E: c = 7'h41;
      6'h1F: c = 7'h53;
      6'h20: c = 7'h44;
      6'h21: c = 7'h46;
      6'h22: c = 7'h47;
      6'h23: c = 7'h48;
      6'h24: c = 7'h4A;
      6'h25: c = 7'h4B;
      6'h26: c = 7'h4C;
      6'h27: c = 7'h3A;
      6'h28: c = 7'h22;
      6'h29: c = 7'h7E;
      6'h2B: c = 7'h7C;
      6'h2C: c = 7'h5A;
      6'h2D: c = 7'h58;
      6'h2E: c = 7'h43;
      6'h2F: c = 7'h56;
      6'h30: c = 7'h42;
      6'h31: c = 7'h4E;
      6'h32: c = 7'h4D;
      6'h33: c = 7'h3C;
      6'h34: c = 7'h3E;
      6'h35: c = 7'h3F;
      6'h39: c = 7'h20;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/scle_ram.sv =====
// generic single write port ram with registered read
// no dependencies

module scle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== sv/scle_keymap.sv =====
// modifier flags and scan code classification with ascii mapping
// depends on scle_pkg

module scle_keymap (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [7:0]          code,
  output scle_pkg::key_info_t info
);

  logic shift_r, shift_nxt;
  logic ctrl_r, ctrl_nxt;
  logic alt_r, alt_nxt;
  logic caps_r, caps_nxt;

  logic [scle_pkg::CHAR_W-1:0] base;
  logic [scle_pkg::CHAR_W-1:0] shifted;
  logic                        letter;
  logic                        upper;
  logic                        fkey;

  always_comb begin
    shift_nxt = shift_r;
    ctrl_nxt  = ctrl_r;
    alt_nxt   = alt_r;
    caps_nxt  = caps_r;
    if (adv) begin
      case (code)
        scle_pkg::SC_CTRL_MAKE:   ctrl_nxt  = 1'b1;
        scle_pkg::SC_CTRL_BREAK:  ctrl_nxt  = 1'b0;
        scle_pkg::SC_ALT_MAKE:    alt_nxt   = 1'b1;
        scle_pkg::SC_ALT_BREAK:   alt_nxt   = 1'b0;
        scle_pkg::SC_SHIFT_MAKE:  shift_nxt = 1'b1;
        scle_pkg::SC_SHIFT_BREAK: shift_nxt = 1'b0;
        scle_pkg::SC_CAPS_BREAK:  caps_nxt  = ~caps_r;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= 1'b0;
      ctrl_r  <= 1'b0;
      alt_r   <= 1'b0;
      caps_r  <= 1'b0;
    end else begin
      shift_r <= shift_nxt;
      ctrl_r  <= ctrl_nxt;
      alt_r   <= alt_nxt;
      caps_r  <= caps_nxt;
    end
  end

  always_comb begin
    base    = (code[7:6] == 2'b00) ? scle_pkg::plain_char(code[5:0]) : '0;
    shifted = scle_pkg::shift_char(code[5:0]);
    letter  = (base >= scle_pkg::ASCII_LC_A) && (base <= scle_pkg::ASCII_LC_Z);
    upper   = letter ? (shift_r ^ caps_r) : shift_r;
    fkey    = (code >= scle_pkg::SC_F1) && (code <= scle_pkg::SC_F3);

    info.ch     = upper ? shifted : base;
    info.target = code[1:0] - scle_pkg::SC_F1[1:0];
    if (ctrl_r && (code == scle_pkg::SC_L)) begin
      info.kind = scle_pkg::KEY_CLEAR;
    end else if (fkey) begin
      info.kind = alt_r ? scle_pkg::KEY_SWITCH : scle_pkg::KEY_NONE;
    end else if (base != '0) begin
      if (code == scle_pkg::SC_TAB) begin
        info.kind = scle_pkg::KEY_TAB;
      end else if (code == scle_pkg::SC_BKSP) begin
        info.kind = scle_pkg::KEY_BKSP;
      end else begin
        info.kind = scle_pkg::KEY_CHAR;
      end
    end else begin
      info.kind = scle_pkg::KEY_NONE;
    end
  end

endmodule

// ===== sv/scle_line.sv =====
// edit line: character count, line store ram and last-entry tab tracking
// depends on scle_pkg and scle_ram

module scle_line (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  scle_pkg::key_info_t info,
  output scle_pkg::result_t   res
);

  localparam logic [scle_pkg::CNT_W-1:0] LAST_IDX = scle_pkg::CNT_W'(scle_pkg::LINE_DEPTH - 1);

  logic [scle_pkg::CNT_W-1:0] count_r, count_nxt, count_new;
  // tab flag of entry count-1
  logic                       top_tab_r, top_tab_nxt, top_tab_new;
  logic                       wr_en;
  logic [scle_pkg::CHAR_W-1:0] wr_data;
  logic [scle_pkg::CHAR_W-1:0] rd_data;
  logic [scle_pkg::CNT_W-1:0] rd_addr;
  logic                       full;

  always_comb begin
    full        = (count_r == LAST_IDX);
    count_new   = count_r;
    top_tab_new = top_tab_r;
    wr_en       = 1'b0;
    wr_data     = info.ch;

    res.echo_char     = '0;
    res.echo_count    = scle_pkg::ECHO_NONE;
    res.clear_req     = 1'b0;
    res.switch_valid  = 1'b0;
    res.switch_target = '0;
    res.deleted_tab   = 1'b0;
    res.line_wrapped  = 1'b0;

    case (info.kind)
      scle_pkg::KEY_CLEAR: begin
        count_new     = '0;
        res.clear_req = 1'b1;
      end
      scle_pkg::KEY_SWITCH: begin
        res.switch_valid  = 1'b1;
        res.switch_target = info.target;
      end
      scle_pkg::KEY_TAB: begin
        if (!full) begin
          wr_en          = 1'b1;
          wr_data        = scle_pkg::ASCII_TAB;
          count_new      = count_r + scle_pkg::CNT_W'(1);
          top_tab_new    = 1'b1;
          res.echo_char  = scle_pkg::ASCII_SPACE;
          res.echo_count = scle_pkg::ECHO_TAB;
        end
      end
      scle_pkg::KEY_BKSP: begin
        if (!full && (count_r != '0)) begin
          count_new       = count_r - scle_pkg::CNT_W'(1);
          res.deleted_tab = top_tab_r;
          top_tab_new     = (rd_data == scle_pkg::ASCII_TAB);
          res.echo_char   = scle_pkg::ASCII_BS;
          res.echo_count  = scle_pkg::ECHO_ONCE;
        end
      end
      scle_pkg::KEY_CHAR: begin
        if (!full) begin
          wr_en          = 1'b1;
          count_new      = count_r + scle_pkg::CNT_W'(1);
          top_tab_new    = 1'b0;
          res.echo_char  = info.ch;
          res.echo_count = scle_pkg::ECHO_ONCE;
        end else if (info.ch == scle_pkg::ASCII_LF) begin
          // full line: newline goes to the last slot and the count wraps
          wr_en            = 1'b1;
          count_new        = '0;
          res.echo_char    = scle_pkg::ASCII_LF;
          res.echo_count   = scle_pkg::ECHO_ONCE;
          res.line_wrapped = 1'b1;
        end
      end
      default: ;
    endcase

    res.line_length = 7'(count_new);
    count_nxt       = adv ? count_new : count_r;
    top_tab_nxt     = adv ? top_tab_new : top_tab_r;
    // prefetch entry count-2 for the next item
    rd_addr         = count_nxt - scle_pkg::CNT_W'(2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      top_tab_r <= 1'b0;
    end else begin
      count_r   <= count_nxt;
      top_tab_r <= top_tab_nxt;
    end
  end

  scle_ram #(
    .WIDTH (scle_pkg::CHAR_W),
    .DEPTH (scle_pkg::LINE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en && adv),
    .wr_addr (count_r),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

// ===== sv/scan_code_line_editor.sv =====
// top level of the scan code line editor: input register, key decode,
// edit line and result register; depends on scle_pkg, scle_keymap, scle_line
// throughput: one item per cycle while out_stall is low, set by the single pass
// from input register through key decode and edit line to result register
// reset: synchronous active low; clears modifiers, line count and valid flags
// the line store ram is not cleared and needs no sweep after reset

module scan_code_line_editor (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_code,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_echo_char,
  output logic [2:0] out_echo_count,
  output logic       out_clear_req,
  output logic       out_switch_valid,
  output logic [1:0] out_switch_target,
  output logic       out_deleted_tab,
  output logic [6:0] out_line_length,
  output logic       out_line_wrapped
);

  logic               s1_valid_r, s1_valid_nxt;
  logic [7:0]         s1_code_r;
  logic               out_valid_r, out_valid_nxt;
  scle_pkg::result_t  out_res_r;
  scle_pkg::result_t  res;
  scle_pkg::key_info_t info;
  logic               adv;
  logic               in_take;

  assign adv      = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = adv ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_code_r <= in_scan_code;
    end
    if (adv) begin
      out_res_r <= res;
    end
  end

  scle_keymap u_keymap (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .code  (s1_code_r),
    .info  (info)
  );

  scle_line u_line (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .info  (info),
    .res   (res)
  );

  assign out_valid         = out_valid_r;
  assign out_echo_char     = out_res_r.echo_char;
  assign out_echo_count    = out_res_r.echo_count;
  assign out_clear_req     = out_res_r.clear_req;
  assign out_switch_valid  = out_res_r.switch_valid;
  assign out_switch_target = out_res_r.switch_target;
  assign out_deleted_tab   = out_res_r.deleted_tab;
  assign out_line_length   = out_res_r.line_length;
  assign out_line_wrapped  = out_res_r.line_wrapped;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_clear_req, out_switch_valid,
                               out_echo_count != scle_pkg::ECHO_NONE}) <= 1))
    else $error("more than one action in one result item");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_clear_req || out_line_wrapped)) |-> (out_line_length == '0))
    else $error("clear or wrap left a nonempty line");

  a_echo_count_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_echo_count == scle_pkg::ECHO_NONE ||
                   out_echo_count == scle_pkg::ECHO_ONCE ||
                   out_echo_count == scle_pkg::ECHO_TAB))
    else $error("bad echo count");

  a_wrap_newline: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_line_wrapped) |-> (out_echo_char == scle_pkg::ASCII_LF))
    else $error("line wrap without newline echo");

endmodule

// ===== sim/scle_echo_checker.sv =====
// result checker for the scan code line editor: tracks modifiers and the edit line,
// predicts one result item per accepted scan code and compares the result channel
// depends on scle_pkg
module scle_echo_checker (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] in_scan_code,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [6:0] out_echo_char,
  input  logic [2:0] out_echo_count,
  input  logic       out_clear_req,
  input  logic       out_switch_valid,
  input  logic [1:0] out_switch_target,
  input  logic       out_deleted_tab,
  input  logic [6:0] out_line_length,
  input  logic       out_line_wrapped,
  output int         mismatches,
  output int         expected_left
);

  // key rows indexed by scan code; '!' marks no key in the plain row, '.' in the shifted row
  localparam logic [8*64-1:0] PLAIN_ROW =
    {"!!1234567890-=!!", "qwertyuiop[]!!as", "dfghjkl;'`!\\zxcv", "bnm,./!!! !!!!!!"};
  localparam logic [8*64-1:0] SHIFT_ROW =
    {"..!@#$%^&*()_+..", "QWERTYUIOP{}..AS", "DFGHJKL:\"~.|ZXCV", "BNM<>?... ......"};

  logic                        shift_down;
  logic                        ctrl_down;
  logic                        alt_down;
  logic                        caps_lock;
  logic [scle_pkg::CHAR_W-1:0] line_buf [scle_pkg::LINE_DEPTH];
  int                          line_len;
  scle_pkg::result_t           echo_expect_q [$];

  function automatic logic [scle_pkg::CHAR_W-1:0] key_char(input logic [7:0] sc,
                                                           input logic shifted);
    logic [7:0] b;
    int         idx;
    idx = int'(sc[5:0]);
    if (sc == scle_pkg::SC_BKSP) begin
      key_char = scle_pkg::ASCII_BS;
    end else if (sc == scle_pkg::SC_TAB) begin
      key_char = scle_pkg::ASCII_TAB;
    end else if (sc == scle_pkg::SC_ENTER) begin
      key_char = scle_pkg::ASCII_LF;
    end else if (sc[7:6] != 2'b00) begin
      key_char = '0;
    end else if (shifted) begin
      b = SHIFT_ROW[8*(63-idx) +: 8];
      key_char = (b == ".") ? '0 : b[6:0];
    end else begin
      b = PLAIN_ROW[8*(63-idx) +: 8];
      key_char = (b == "!") ? '0 : b[6:0];
    end
  endfunction

  task automatic decode_scan_code(input logic [7:0] sc);
    scle_pkg::result_t           r;
    logic [scle_pkg::CHAR_W-1:0] base_ch;
    logic [scle_pkg::CHAR_W-1:0] ch;
    logic [7:0]                  fnum;
    logic                        letter;
    logic                        up;
    r = '0;
    base_ch = key_char(sc, 1'b0);
    case (sc)
      scle_pkg::SC_CTRL_MAKE:   ctrl_down = 1'b1;
      scle_pkg::SC_ALT_MAKE:    alt_down = 1'b1;
      scle_pkg::SC_SHIFT_MAKE:  shift_down = 1'b1;
      scle_pkg::SC_CAPS_BREAK:  caps_lock = !caps_lock;
      scle_pkg::SC_SHIFT_BREAK: shift_down = 1'b0;
      scle_pkg::SC_CTRL_BREAK:  ctrl_down = 1'b0;
      scle_pkg::SC_ALT_BREAK:   alt_down = 1'b0;
      default: ;
    endcase
    if (ctrl_down && sc == scle_pkg::SC_L) begin
      line_len = 0;
      r.clear_req = 1'b1;
    end else if (sc >= scle_pkg::SC_F1 && sc <= scle_pkg::SC_F3) begin
      if (alt_down) begin
        fnum = sc - scle_pkg::SC_F1;
        r.switch_valid = 1'b1;
        r.switch_target = fnum[1:0];
      end
    end else if (base_ch != '0) begin
      if (line_len < scle_pkg::LINE_DEPTH - 1) begin
        if (sc == scle_pkg::SC_TAB) begin
          line_buf[line_len] = scle_pkg::ASCII_TAB;
          line_len++;
          r.echo_char = scle_pkg::ASCII_SPACE;
          r.echo_count = scle_pkg::ECHO_TAB;
        end else if (sc == scle_pkg::SC_BKSP) begin
          if (line_len > 0) begin
            line_len--;
            r.deleted_tab = (line_buf[line_len] == scle_pkg::ASCII_TAB);
            r.echo_char = scle_pkg::ASCII_BS;
            r.echo_count = scle_pkg::ECHO_ONCE;
          end
        end else begin
          letter = (base_ch >= scle_pkg::ASCII_LC_A && base_ch <= scle_pkg::ASCII_LC_Z);
          up = letter ? (shift_down != caps_lock) : shift_down;
          ch = up ? key_char(sc, 1'b1) : base_ch;
          line_buf[line_len] = ch;
          line_len++;
          r.echo_char = ch;
          r.echo_count = scle_pkg::ECHO_ONCE;
        end
      end else if (sc == scle_pkg::SC_ENTER) begin
        line_buf[scle_pkg::LINE_DEPTH-1] = scle_pkg::ASCII_LF;
        line_len = 0;
        r.echo_char = scle_pkg::ASCII_LF;
        r.echo_count = scle_pkg::ECHO_ONCE;
        r.line_wrapped = 1'b1;
      end
    end
    r.line_length = line_len[6:0];
    echo_expect_q.push_back(r);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    scle_pkg::result_t want;
    if (!rst_n) begin
      shift_down = 1'b0;
      ctrl_down = 1'b0;
      alt_down = 1'b0;
      caps_lock = 1'b0;
      line_len = 0;
      echo_expect_q.delete();
      mismatches = 0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_scan_code(in_scan_code);
      end
      if (out_valid && !out_stall) begin
        if (echo_expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result item with no scan code waiting", $time);
          end
        end else begin
          want = echo_expect_q.pop_front();
          check_field("echo_char", want.echo_char, out_echo_char);
          check_field("echo_count", want.echo_count, out_echo_count);
          check_field("clear_req", want.clear_req, out_clear_req);
          check_field("switch_valid", want.switch_valid, out_switch_valid);
          check_field("switch_target", want.switch_target, out_switch_target);
          check_field("deleted_tab", want.deleted_tab, out_deleted_tab);
          check_field("line_length", want.line_length, out_line_length);
          check_field("line_wrapped", want.line_wrapped, out_line_wrapped);
        end
      end
    end
    expected_left = echo_expect_q.size();
  end

endmodule

// ===== sim/tb.sv =====
// testbench top for the scan code line editor: clock, reset, scan code stimulus,
// random idling on both channels and the verdict
// depends on scle_pkg, scan_code_line_editor and scle_echo_checker
module tb;

  localparam logic [7:0] SC_RSHIFT_MAKE = 8'h36;
  localparam logic [7:0] SC_KP_STAR     = 8'h37;
  localparam logic [7:0] SC_SPACE       = 8'h39;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_scan_code;
  logic       out_valid;
  logic       out_stall;
  logic [6:0] out_echo_char;
  logic [2:0] out_echo_count;
  logic       out_clear_req;
  logic       out_switch_valid;
  logic [1:0] out_switch_target;
  logic       out_deleted_tab;
  logic [6:0] out_line_length;
  logic       out_line_wrapped;
  int         mismatches;
  int         expected_left;
  int         send_gap_pct;
  int         recv_stall_pct;
  int         cycle_no;

  always #4 clk = ~clk;

  scan_code_line_editor dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_scan_code(in_scan_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_echo_char(out_echo_char), .out_echo_count(out_echo_count),
    .out_clear_req(out_clear_req), .out_switch_valid(out_switch_valid),
    .out_switch_target(out_switch_target), .out_deleted_tab(out_deleted_tab),
    .out_line_length(out_line_length), .out_line_wrapped(out_line_wrapped)
  );

  scle_echo_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_scan_code(in_scan_code),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_echo_char(out_echo_char), .out_echo_count(out_echo_count),
    .out_clear_req(out_clear_req), .out_switch_valid(out_switch_valid),
    .out_switch_target(out_switch_target), .out_deleted_tab(out_deleted_tab),
    .out_line_length(out_line_length), .out_line_wrapped(out_line_wrapped),
    .mismatches(mismatches), .expected_left(expected_left)
  );

  task automatic send_scan_code(input logic [7:0] code);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_scan_code <= code;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // any key that stores a character
  function automatic logic [7:0] printable_code();
    logic [7:0] c;
    c = 8'($urandom_range(8'h02, SC_SPACE));
    while (c == scle_pkg::SC_BKSP || c == scle_pkg::SC_TAB || c == scle_pkg::SC_ENTER ||
           c == scle_pkg::SC_CTRL_MAKE || c == scle_pkg::SC_SHIFT_MAKE ||
           c == SC_RSHIFT_MAKE || c == SC_KP_STAR || c == scle_pkg::SC_ALT_MAKE) begin
      c = 8'($urandom_range(8'h02, SC_SPACE));
    end
    return c;
  endfunction

  task automatic random_key_event();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) send_scan_code(printable_code());
    else if (r < 60) send_scan_code(scle_pkg::SC_SHIFT_MAKE);
    else if (r < 65) send_scan_code(scle_pkg::SC_SHIFT_BREAK);
    else if (r < 68) send_scan_code(scle_pkg::SC_CAPS_BREAK);
    else if (r < 72) send_scan_code(scle_pkg::SC_TAB);
    else if (r < 80) send_scan_code(scle_pkg::SC_BKSP);
    else if (r < 84) send_scan_code(scle_pkg::SC_ENTER);
    else if (r < 85) send_scan_code(scle_pkg::SC_CTRL_MAKE);
    else if (r < 86) send_scan_code(scle_pkg::SC_CTRL_BREAK);
    else if (r < 87) send_scan_code(scle_pkg::SC_ALT_MAKE);
    else if (r < 88) send_scan_code(scle_pkg::SC_ALT_BREAK);
    else if (r < 91) send_scan_code(scle_pkg::SC_F1 + 8'($urandom_range(0, 2)));
    else if (r < 93) send_scan_code(scle_pkg::SC_L);
    else send_scan_code(8'($urandom_range(0, 255)));
  endtask

  // empty the line, type it full, try keys that a full line ignores, then wrap with enter
  task automatic fill_line();
    send_scan_code(scle_pkg::SC_CTRL_MAKE);
    send_scan_code(scle_pkg::SC_L);
    send_scan_code(scle_pkg::SC_CTRL_BREAK);
    repeat (scle_pkg::LINE_DEPTH - 1) send_scan_code(printable_code());
    send_scan_code(scle_pkg::SC_BKSP);
    send_scan_code(scle_pkg::SC_TAB);
    send_scan_code(printable_code());
    send_scan_code(SC_SPACE);
    send_scan_code(scle_pkg::SC_ENTER);
  endtask

  task automatic run_phase(input int gap_pct, input int stall_pct);
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    repeat (100) random_key_event();
    fill_line();
    repeat (115) random_key_event();
  endtask

  // receiver, with one long hold-off so the block backs up into its input
  initial begin
    out_stall = 1'b0;
    cycle_no = 0;
    forever begin
      @(posedge clk);
      cycle_no++;
      if (cycle_no >= 800 && cycle_no < 1000) out_stall <= 1'b1;
      else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_scan_code = 8'h00;
    send_gap_pct = 33;
    recv_stall_pct = 79;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_scan_code(8'h00);
    send_scan_code(8'hFF);
    send_scan_code(scle_pkg::SC_BKSP);
    send_scan_code(8'h10);
    send_scan_code(scle_pkg::SC_SHIFT_MAKE);
    send_scan_code(8'h02);
    send_scan_code(8'h10);
    send_scan_code(SC_SPACE);
    send_scan_code(scle_pkg::SC_SHIFT_BREAK);
    send_scan_code(scle_pkg::SC_CAPS_BREAK);
    send_scan_code(8'h1E);
    send_scan_code(8'h02);
    send_scan_code(scle_pkg::SC_SHIFT_MAKE);
    send_scan_code(8'h1E);
    send_scan_code(scle_pkg::SC_SHIFT_BREAK);
    send_scan_code(scle_pkg::SC_CAPS_BREAK);
    send_scan_code(scle_pkg::SC_TAB);
    send_scan_code(scle_pkg::SC_BKSP);
    send_scan_code(scle_pkg::SC_BKSP);
    send_scan_code(scle_pkg::SC_F1);
    send_scan_code(scle_pkg::SC_ALT_MAKE);
    send_scan_code(scle_pkg::SC_F1);
    send_scan_code(scle_pkg::SC_F1 + 8'd1);
    send_scan_code(scle_pkg::SC_F3);
    send_scan_code(scle_pkg::SC_ALT_BREAK);
    send_scan_code(scle_pkg::SC_ENTER);
    send_scan_code(scle_pkg::SC_CTRL_MAKE);
    send_scan_code(scle_pkg::SC_L);
    send_scan_code(scle_pkg::SC_CTRL_BREAK);

    run_phase(33, 79);
    run_phase(79, 33);
    run_phase(0, 0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_left == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== scan_code_line_editor.f =====
sv/scle_pkg.sv
sv/scle_ram.sv
sv/scle_keymap.sv
sv/scle_line.sv
sv/scan_code_line_editor.sv
sim/scle_echo_checker.sv
sim/tb.sv
